@@ hdl/tte_pkg.sv @@
// Shared types and constants for the escape/cursor terminal core.
// Holds the operation codes passed from front end to back end and the queue status.
// No dependencies.
package tte_pkg;

    // Operation decoded by the front end, carried out by the back end
    typedef enum logic [3:0] {
        OP_NOP,
        OP_PRINT,
        OP_LF,
        OP_CR,
        OP_TAB,
        OP_UP,
        OP_DOWN,
        OP_RIGHT,
        OP_LEFT,
        OP_HOME,
        OP_CLEAR,
        OP_ERASE,
        OP_PLACE_RC,
        OP_PLACE_CR
    } t_op;

    // Drawing command on the result stream
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_DRAW  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_ERASE = 2'd3
    } t_cmd;

    // One queued operation: data is the glyph or the second coordinate,
    // coord is the first coordinate (both already offset-corrected)
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [7:0] coord;
    } t_item;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             empty;
    } t_fifo_stat;

endpackage

@@ hdl/tte_front.sv @@
// Front end: escape-sequence parser that turns each received byte into one operation.
// Depends on tte_pkg.
module tte_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_ready,
    output logic          o_push,
    output tte_pkg::t_item o_item
);
    import tte_pkg::*;

    localparam logic [7:0] CHR_ESC       = 8'h1b;
    localparam logic [7:0] CHR_LAST_CTRL = 8'h1f;
    localparam logic [7:0] CHR_LF        = 8'h0a;
    localparam logic [7:0] CHR_CR        = 8'h0d;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_LBRACKET  = 8'h5b;
    localparam logic [7:0] CHR_A         = 8'h41;
    localparam logic [7:0] CHR_B         = 8'h42;
    localparam logic [7:0] CHR_C         = 8'h43;
    localparam logic [7:0] CHR_D         = 8'h44;
    localparam logic [7:0] CHR_H         = 8'h48;
    localparam logic [7:0] CHR_J         = 8'h4a;
    localparam logic [7:0] CHR_K         = 8'h4b;
    localparam logic [7:0] CHR_X         = 8'h58;
    localparam logic [7:0] CHR_Y         = 8'h59;
    localparam logic [7:0] COORD_OFFSET  = 8'o37;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ESC,
        ST_CSI,
        ST_COORD1,
        ST_COORD2
    } t_state;

    t_state     r_stage, n_stage;
    logic       r_row_first, n_row_first;
    logic [7:0] r_first_coord, n_first_coord;
    t_item      w_item;

    assign o_push = i_valid && i_ready;
    assign o_item = w_item;

    always_comb begin
        n_stage       = ST_IDLE;
        n_row_first   = r_row_first;
        n_first_coord = r_first_coord;
        w_item.op     = OP_NOP;
        w_item.data   = i_byte;
        w_item.coord  = r_first_coord - COORD_OFFSET;
        case (r_stage)
            ST_ESC: begin
                n_stage = (i_byte == CHR_LBRACKET) ? ST_CSI : ST_IDLE;
            end
            ST_CSI: begin
                case (i_byte)
                    CHR_A: w_item.op = OP_UP;
                    CHR_B: w_item.op = OP_DOWN;
                    CHR_C: w_item.op = OP_RIGHT;
                    CHR_D: w_item.op = OP_LEFT;
                    CHR_H: w_item.op = OP_HOME;
                    CHR_J: w_item.op = OP_CLEAR;
                    CHR_K: w_item.op = OP_ERASE;
                    CHR_X, CHR_Y: begin
                        n_row_first = (i_byte == CHR_Y);
                        n_stage     = ST_COORD1;
                    end
                    default: w_item.op = OP_NOP;
                endcase
            end
            ST_COORD1: begin
                n_first_coord = i_byte;
                n_stage       = ST_COORD2;
            end
            ST_COORD2: begin
                w_item.op   = r_row_first ? OP_PLACE_RC : OP_PLACE_CR;
                w_item.data = i_byte - COORD_OFFSET;
            end
            default: begin
                // idle; unreachable codes behave the same
                if (i_byte == CHR_ESC) begin
                    n_stage = ST_ESC;
                end else if (i_byte > CHR_LAST_CTRL) begin
                    w_item.op = OP_PRINT;
                end else if (i_byte == CHR_LF) begin
                    w_item.op = OP_LF;
                end else if (i_byte == CHR_CR) begin
                    w_item.op = OP_CR;
                end else if (i_byte == CHR_TAB) begin
                    w_item.op = OP_TAB;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage       <= ST_IDLE;
            r_row_first   <= 1'b0;
            r_first_coord <= 8'd0;
        end else if (o_push) begin
            r_stage       <= n_stage;
            r_row_first   <= n_row_first;
            r_first_coord <= n_first_coord;
        end
    end

endmodule

@@ hdl/tte_fifo.sv @@
// Short queue of decoded operations between front end and back end.
// Depends on tte_pkg.
module tte_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tte_pkg::t_item     i_item,
    input  logic               i_pop,
    output tte_pkg::t_item     o_item,
    output tte_pkg::t_fifo_stat o_stat
);
    import tte_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

@@ hdl/tte_back.sv @@
// Back end: applies queued operations to the cursor and registers one result each.
// Depends on tte_pkg.
module tte_back #(
    parameter int GRID_COLS       = 30,
    parameter int GRID_ROWS       = 18,
    parameter int TAB_WIDTH       = 3,
    parameter int CELL_WIDTH      = 8,
    parameter int CELL_HEIGHT     = 16,
    parameter int TOP_MARGIN_ROWS = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tte_pkg::t_item  i_item,
    input  logic            i_avail,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output tte_pkg::t_cmd   o_command,
    output logic [7:0]      o_glyph,
    output logic [7:0]      o_x_start,
    output logic [8:0]      o_y_start,
    output logic [7:0]      o_x_end,
    output logic [8:0]      o_y_end,
    output logic [4:0]      o_cursor_row,
    output logic [4:0]      o_cursor_col
);
    import tte_pkg::*;

    localparam int         RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int         CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam logic [7:0] X_END = 8'(GRID_COLS * CELL_WIDTH);

    // constant tables: byte modulo grid size, next tab stop per column
    logic [RW-1:0] w_row_mod  [256];
    logic [CW-1:0] w_col_mod  [256];
    logic [CW-1:0] w_tab_stop [2**CW];
    logic          w_tab_ok   [2**CW];

    for (genvar gi = 0; gi < 256; gi++) begin : g_mod
        assign w_row_mod[gi] = RW'(gi % GRID_ROWS);
        assign w_col_mod[gi] = CW'(gi % GRID_COLS);
    end
    for (genvar gi = 0; gi < 2**CW; gi++) begin : g_tab
        assign w_tab_stop[gi] = CW'(gi + TAB_WIDTH - (gi % TAB_WIDTH));
        assign w_tab_ok[gi]   = (gi + TAB_WIDTH - (gi % TAB_WIDTH)) < GRID_COLS;
    end

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic          r_valid;
    t_cmd          r_cmd, n_cmd;
    logic [7:0]    r_glyph, n_glyph;
    logic [7:0]    r_xs, n_xs;
    logic [8:0]    r_ys, n_ys;
    logic [7:0]    r_xe, n_xe;
    logic [8:0]    r_ye, n_ye;

    logic [RW-1:0] w_row_inc, w_row_dec;
    logic [CW-1:0] w_col_inc, w_col_dec;
    logic [7:0]    w_row_idx, w_col_idx;
    logic [7:0]    w_cell_x;
    logic [8:0]    w_cell_y, w_cell_y_end;

    assign o_pop = i_avail && (!r_valid || i_ready);

    assign w_row_inc = (r_row == RW'(GRID_ROWS - 1)) ? '0 : r_row + 1'b1;
    assign w_row_dec = (r_row == '0) ? RW'(GRID_ROWS - 1) : r_row - 1'b1;
    assign w_col_inc = (r_col == CW'(GRID_COLS - 1)) ? '0 : r_col + 1'b1;
    assign w_col_dec = (r_col == '0) ? CW'(GRID_COLS - 1) : r_col - 1'b1;

    assign w_row_idx = (i_item.op == OP_PLACE_RC) ? i_item.coord : i_item.data;
    assign w_col_idx = (i_item.op == OP_PLACE_RC) ? i_item.data : i_item.coord;

    assign w_cell_x     = 8'(int'(r_col) * CELL_WIDTH);
    assign w_cell_y     = 9'((TOP_MARGIN_ROWS + int'(r_row)) * CELL_HEIGHT);
    assign w_cell_y_end = 9'((TOP_MARGIN_ROWS + int'(r_row) + 1) * CELL_HEIGHT);

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_cmd   = CMD_NONE;
        n_glyph = 8'd0;
        n_xs    = 8'd0;
        n_ys    = 9'd0;
        n_xe    = 8'd0;
        n_ye    = 9'd0;
        case (i_item.op)
            OP_PRINT: begin
                n_cmd   = CMD_DRAW;
                n_glyph = i_item.data;
                n_xs    = w_cell_x;
                n_ys    = w_cell_y;
                n_col   = w_col_inc;
                if (r_col == CW'(GRID_COLS - 1)) begin
                    n_row = w_row_inc;
                end
            end
            OP_LF, OP_DOWN: n_row = w_row_inc;
            OP_CR:          n_col = '0;
            OP_TAB: begin
                if (w_tab_ok[r_col]) begin
                    n_col = w_tab_stop[r_col];
                end else begin
                    n_col = '0;
                    n_row = w_row_inc;
                end
            end
            OP_UP:    n_row = w_row_dec;
            OP_RIGHT: n_col = w_col_inc;
            OP_LEFT:  n_col = w_col_dec;
            OP_HOME: begin
                n_row = '0;
                n_col = '0;
            end
            OP_CLEAR: n_cmd = CMD_CLEAR;
            OP_ERASE: begin
                n_cmd = CMD_ERASE;
                n_xs  = w_cell_x;
                n_ys  = w_cell_y;
                n_xe  = X_END;
                n_ye  = w_cell_y_end;
            end
            OP_PLACE_RC, OP_PLACE_CR: begin
                n_row = w_row_mod[w_row_idx];
                n_col = w_col_mod[w_col_idx];
            end
            default: n_cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd   <= n_cmd;
            r_glyph <= n_glyph;
            r_xs    <= n_xs;
            r_ys    <= n_ys;
            r_xe    <= n_xe;
            r_ye    <= n_ye;
        end
    end

    logic [RW-1:0] r_row_out;
    logic [CW-1:0] r_col_out;
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_row_out <= n_row;
            r_col_out <= n_col;
        end
    end

    assign o_valid      = r_valid;
    assign o_command    = r_cmd;
    assign o_glyph      = r_glyph;
    assign o_x_start    = r_xs;
    assign o_y_start    = r_ys;
    assign o_x_end      = r_xe;
    assign o_y_end      = r_ye;
    assign o_cursor_row = 5'(r_row_out);
    assign o_cursor_col = 5'(r_col_out);

endmodule

@@ hdl/text_terminal_escape_cursor_core.sv @@
// Terminal escape parser and cursor tracker: one result transaction per received byte.
// Path: an accepted byte is stored in the operation queue, then popped into the result register on the master side.
// Throughput: one byte per cycle, sustained; set by the two-entry operation queue and the
// result register, which both pass a transaction every cycle when the sink is ready.
// Reset (i_rst_n low, synchronous): cursor to row 0 column 0, parser idle, queue and result empty.
// Depends on tte_pkg, tte_front, tte_fifo, tte_back.
module text_terminal_escape_cursor_core #(
    parameter int GRID_COLS       = 30,
    parameter int GRID_ROWS       = 18,
    parameter int TAB_WIDTH       = 3,
    parameter int CELL_WIDTH      = 8,
    parameter int CELL_HEIGHT     = 16,
    parameter int TOP_MARGIN_ROWS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // result stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [7:0] glyph, [15:8] x_start, [24:16] y_start,
                                     // [32:25] x_end, [41:33] y_end, [46:42] cursor_row_out,
                                     // [51:47] cursor_col_out, [55:52] zero
    output logic [1:0]  o_m_tuser    // [1:0] command
);
    import tte_pkg::*;

    // front end -> queue
    logic       w_push;
    t_item      w_front_item;
    // queue -> back end
    t_item      w_queue_item;
    t_fifo_stat w_fifo_stat;
    logic       w_pop;
    // result fields
    t_cmd       w_cmd;
    logic [7:0] w_glyph, w_xs, w_xe;
    logic [8:0] w_ys, w_ye;
    logic [4:0] w_row, w_col;

    // Take a byte whenever the queue has room; the sink side never throttles this directly.
    assign o_s_tready = !w_fifo_stat.full;

    // Parse escapes and classify each byte into an operation
    tte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_ready (o_s_tready),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    // Hold operations so parser and cursor side can stall independently
    tte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_stat  (w_fifo_stat)
    );

    // Advance the cursor and register the drawing command
    tte_back #(
        .GRID_COLS       (GRID_COLS),
        .GRID_ROWS       (GRID_ROWS),
        .TAB_WIDTH       (TAB_WIDTH),
        .CELL_WIDTH      (CELL_WIDTH),
        .CELL_HEIGHT     (CELL_HEIGHT),
        .TOP_MARGIN_ROWS (TOP_MARGIN_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_queue_item),
        .i_avail      (!w_fifo_stat.empty),
        .o_pop        (w_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_command    (w_cmd),
        .o_glyph      (w_glyph),
        .o_x_start    (w_xs),
        .o_y_start    (w_ys),
        .o_x_end      (w_xe),
        .o_y_end      (w_ye),
        .o_cursor_row (w_row),
        .o_cursor_col (w_col)
    );

    // Pack the result fields, lowest field first, padded to whole bytes
    assign o_m_tdata = {4'd0, w_col, w_row, w_ye, w_xe, w_ys, w_xs, w_glyph};
    assign o_m_tuser = w_cmd;

    // Queue occupancy follows pushes and pops exactly
    a_fifo_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (w_fifo_stat.count ==
                     CNT_W'($past(w_fifo_stat.count) + CNT_W'($past(w_push))
                            - CNT_W'($past(w_pop)))))
        else $error("queue count out of step with push/pop");

    // A pop never happens on an empty queue
    a_no_pop_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_stat.empty)
        else $error("pop from empty queue");

    // Results without drawing geometry carry zeroed glyph and coordinates
    a_idle_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == CMD_NONE || o_m_tuser == CMD_CLEAR))
        |-> (o_m_tdata[41:0] == 42'd0))
        else $error("geometry present on a non-drawing result");

    // Reported cursor stays on the grid
    a_cursor_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((GRID_ROWS > 32 || int'(w_row) < GRID_ROWS) &&
                        (GRID_COLS > 32 || int'(w_col) < GRID_COLS)))
        else $error("cursor off the grid");

endmodule
